[sv/adp_pkg.sv]
// ============================================================================
// Archive directory parser package
// Shared constants, result kind codes, back-end op codes and the command
// word that travels from the front end to the back end.
// ============================================================================
package adp_pkg;

  localparam logic [31:0] MAGIC_WORD = 32'hBAC04AC0;
  localparam logic [7:0]  KEY_RESET  = 8'hF7;
  localparam logic [7:0]  END_FLAG   = 8'h80;

  typedef enum logic [2:0] {
    KIND_NAME     = 3'd0,
    KIND_ENTRY    = 3'd1,
    KIND_DIREND   = 3'd2,
    KIND_PAYLOAD  = 3'd3,
    KIND_BADMAGIC = 3'd4,
    KIND_BADVER   = 3'd5,
    KIND_TRUNC    = 3'd6,
    KIND_NONE     = 3'd7
  } kind_e;

  // What the back end does with the byte carried in a command.
  typedef enum logic [1:0] {
    OP_PASS  = 2'd0,
    OP_CLEAR = 2'd1,
    OP_SIZE  = 2'd2,
    OP_TIME  = 2'd3
  } op_e;

  typedef struct packed {
    op_e        op;
    kind_e      kind;
    logic [7:0] data;       // decrypted byte, or mapped name character
    logic [2:0] idx;        // byte lane for size and time fields
    logic       name_last;
    logic       encrypted;
    logic       last;       // final byte of the file: restart afterwards
  } cmd_t;

  // Uppercase ASCII letters and turn backslash into slash.
  function automatic logic [7:0] name_char(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c == 8'h5C) begin
      r = 8'h2F;
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      r = c - 8'h20;
    end
    return r;
  endfunction

endpackage

[sv/adp_front.sv]
// ============================================================================
// Archive directory parser front end
// Tracks the file format phase per byte, checks magic and version, and
// issues one command per accepted byte.
// ============================================================================
module adp_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [7:0]        key_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        in_byte_i,
  input  logic              in_last_i,
  input  logic              cmd_ready_i,
  output logic              cmd_valid_o,
  output adp_pkg::cmd_t     cmd_o
);
  import adp_pkg::*;

  localparam logic [3:0] PH_MAGIC   = 4'd0;
  localparam logic [3:0] PH_VERSION = 4'd1;
  localparam logic [3:0] PH_FLAGS   = 4'd2;
  localparam logic [3:0] PH_NAMELEN = 4'd3;
  localparam logic [3:0] PH_NAME    = 4'd4;
  localparam logic [3:0] PH_SIZE    = 4'd5;
  localparam logic [3:0] PH_TIME    = 4'd6;
  localparam logic [3:0] PH_PAYLOAD = 4'd7;
  localparam logic [3:0] PH_DEAD    = 4'd8;

  logic [3:0] phase_q, phase_d;
  logic [2:0] cnt_q, cnt_d;
  logic       raw_ok_q, raw_ok_d;
  logic       key_ok_q, key_ok_d;
  logic       crypt_q, crypt_d;
  logic       ver_nz_q, ver_nz_d;
  logic [7:0] name_left_q, name_left_d;

  logic       accept;
  logic [7:0] d;
  logic [7:0] magic_byte;
  logic [7:0] left_dec;
  kind_e      kind;

  assign in_ready_o  = cmd_ready_i;
  assign cmd_valid_o = in_valid_i;
  assign accept      = in_valid_i & cmd_ready_i;

  assign d          = crypt_q ? (in_byte_i ^ key_i) : in_byte_i;
  assign magic_byte = MAGIC_WORD[{cnt_q[1:0], 3'b000} +: 8];
  assign left_dec   = name_left_q - 8'd1;

  always_comb begin
    phase_d     = phase_q;
    cnt_d       = cnt_q;
    raw_ok_d    = raw_ok_q;
    key_ok_d    = key_ok_q;
    crypt_d     = crypt_q;
    ver_nz_d    = ver_nz_q;
    name_left_d = name_left_q;
    kind        = KIND_NONE;
    cmd_o       = '0;
    cmd_o.op    = OP_PASS;
    cmd_o.data  = d;
    cmd_o.idx   = cnt_q;

    unique case (phase_q)
      PH_MAGIC: begin
        raw_ok_d = raw_ok_q & (in_byte_i == magic_byte);
        key_ok_d = key_ok_q & ((in_byte_i ^ key_i) == magic_byte);
        cnt_d    = cnt_q + 3'd1;
        if (cnt_q == 3'd3) begin
          cnt_d = '0;
          if (raw_ok_d) begin
            crypt_d = 1'b0;
            phase_d = PH_VERSION;
          end else if (key_ok_d) begin
            crypt_d = 1'b1;
            phase_d = PH_VERSION;
          end else begin
            kind    = KIND_BADMAGIC;
            phase_d = PH_DEAD;
          end
        end
        if (in_last_i && kind == KIND_NONE) begin
          kind = KIND_TRUNC;
        end
      end
      PH_VERSION: begin
        ver_nz_d = ver_nz_q | (d != 8'd0);
        cnt_d    = cnt_q + 3'd1;
        if (cnt_q == 3'd3) begin
          cnt_d = '0;
          if (ver_nz_d) begin
            kind    = KIND_BADVER;
            phase_d = PH_DEAD;
          end else begin
            phase_d = PH_FLAGS;
          end
        end
        if (in_last_i && kind == KIND_NONE) begin
          kind = KIND_TRUNC;
        end
      end
      PH_FLAGS: begin
        if ((d & END_FLAG) != 8'd0 || in_last_i) begin
          kind    = KIND_DIREND;
          phase_d = PH_PAYLOAD;
        end else begin
          phase_d = PH_NAMELEN;
        end
      end
      PH_NAMELEN: begin
        cmd_o.op    = OP_CLEAR;
        name_left_d = d;
        cnt_d       = '0;
        phase_d     = (d == 8'd0) ? PH_SIZE : PH_NAME;
        if (in_last_i) begin
          kind = KIND_TRUNC;
        end
      end
      PH_NAME: begin
        if (in_last_i) begin
          kind = KIND_TRUNC;
        end else begin
          kind            = KIND_NAME;
          cmd_o.data      = name_char(d);
          cmd_o.name_last = (name_left_q == 8'd1);
        end
        name_left_d = left_dec;
        if (left_dec == 8'd0) begin
          phase_d = PH_SIZE;
        end
      end
      PH_SIZE: begin
        cmd_o.op = OP_SIZE;
        cnt_d    = cnt_q + 3'd1;
        if (cnt_q == 3'd3) begin
          cnt_d   = '0;
          phase_d = PH_TIME;
        end
        if (in_last_i) begin
          kind = KIND_TRUNC;
        end
      end
      PH_TIME: begin
        cmd_o.op = OP_TIME;
        cnt_d    = cnt_q + 3'd1;
        if (in_last_i) begin
          kind = KIND_TRUNC;
        end else if (cnt_q == 3'd7) begin
          cnt_d   = '0;
          kind    = KIND_ENTRY;
          phase_d = PH_FLAGS;
        end
      end
      PH_PAYLOAD: begin
        kind = KIND_PAYLOAD;
      end
      default: begin
      end
    endcase

    cmd_o.kind      = kind;
    cmd_o.encrypted = (kind == KIND_BADMAGIC) ? 1'b0 : crypt_d;
    cmd_o.last      = in_last_i;

    // The final byte of a file returns the parser to the start of a new one.
    if (in_last_i) begin
      phase_d     = PH_MAGIC;
      cnt_d       = '0;
      raw_ok_d    = 1'b1;
      key_ok_d    = 1'b1;
      crypt_d     = 1'b0;
      ver_nz_d    = 1'b0;
      name_left_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_MAGIC;
      cnt_q       <= '0;
      raw_ok_q    <= 1'b1;
      key_ok_q    <= 1'b1;
      crypt_q     <= 1'b0;
      ver_nz_q    <= 1'b0;
      name_left_q <= '0;
    end else if (accept) begin
      phase_q     <= phase_d;
      cnt_q       <= cnt_d;
      raw_ok_q    <= raw_ok_d;
      key_ok_q    <= key_ok_d;
      crypt_q     <= crypt_d;
      ver_nz_q    <= ver_nz_d;
      name_left_q <= name_left_d;
    end
  end

endmodule

[sv/adp_queue.sv]
// ============================================================================
// Archive directory parser command queue
// Two-entry queue of commands between the front end and the back end.
// ============================================================================
module adp_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  output logic          ready_o,
  input  adp_pkg::cmd_t data_i,
  output logic          valid_o,
  input  logic          pop_i,
  output adp_pkg::cmd_t data_o
);
  import adp_pkg::*;

  cmd_t       mem_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] count_q;
  logic       do_push;
  logic       do_pop;

  assign ready_o = (count_q != 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i & ready_o;
  assign do_pop  = pop_i & valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 2'd1;
      end else if (!do_push && do_pop) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

endmodule

[sv/adp_back.sv]
// ============================================================================
// Archive directory parser back end
// Counts file bytes, gathers size and time fields, keeps the running entry
// start, and holds the result in an output register.
// ============================================================================
module adp_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  output logic          cmd_pop_o,
  input  adp_pkg::cmd_t cmd_i,
  output logic          res_valid_o,
  input  logic          res_ready_i,
  output logic [2:0]    res_kind_o,
  output logic [7:0]    res_byte_o,
  output logic          res_name_last_o,
  output logic [31:0]   res_size_o,
  output logic [31:0]   res_start_o,
  output logic [63:0]   res_time_o,
  output logic [31:0]   res_poff_o,
  output logic          res_encrypted_o
);
  import adp_pkg::*;

  logic [31:0] offset_q;
  logic [31:0] size_acc_q;
  logic [63:0] time_acc_q;
  logic [31:0] run_start_q;
  logic        out_valid_q;

  logic [31:0] offset_inc;
  logic [31:0] size_next;
  logic [63:0] time_next;
  logic        pop;
  logic        has_res;

  assign pop        = cmd_valid_i & (~out_valid_q | res_ready_i);
  assign cmd_pop_o  = pop;
  assign has_res    = (cmd_i.kind != KIND_NONE);
  assign offset_inc = offset_q + 32'd1;

  always_comb begin
    size_next = size_acc_q;
    time_next = time_acc_q;
    unique case (cmd_i.op)
      OP_CLEAR: begin
        size_next = '0;
        time_next = '0;
      end
      OP_SIZE:  size_next[{cmd_i.idx[1:0], 3'b000} +: 8] = cmd_i.data;
      OP_TIME:  time_next[{cmd_i.idx, 3'b000} +: 8] = cmd_i.data;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q    <= '0;
      size_acc_q  <= '0;
      time_acc_q  <= '0;
      run_start_q <= '0;
    end else if (pop) begin
      if (cmd_i.last) begin
        offset_q    <= '0;
        size_acc_q  <= '0;
        time_acc_q  <= '0;
        run_start_q <= '0;
      end else begin
        offset_q   <= offset_inc;
        size_acc_q <= size_next;
        time_acc_q <= time_next;
        if (cmd_i.kind == KIND_ENTRY) begin
          run_start_q <= run_start_q + size_acc_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop) begin
      out_valid_q <= has_res;
    end else if (res_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload; fields that do not belong to the kind read as zero.
  always_ff @(posedge clk_i) begin
    if (pop && has_res) begin
      res_kind_o      <= cmd_i.kind;
      res_encrypted_o <= cmd_i.encrypted;
      res_byte_o      <= (cmd_i.kind == KIND_NAME || cmd_i.kind == KIND_PAYLOAD)
                         ? cmd_i.data : 8'd0;
      res_name_last_o <= (cmd_i.kind == KIND_NAME) ? cmd_i.name_last : 1'b0;
      res_poff_o      <= (cmd_i.kind == KIND_DIREND) ? offset_inc : 32'd0;
      if (cmd_i.kind == KIND_ENTRY) begin
        res_size_o  <= size_acc_q;
        res_start_o <= run_start_q;
        res_time_o  <= time_next;
      end else begin
        res_size_o  <= '0;
        res_start_o <= '0;
        res_time_o  <= '0;
      end
    end
  end

  assign res_valid_o = out_valid_q;

endmodule

[sv/archive_directory_parser_core.sv]
// ============================================================================
// Archive directory parser core
// Parses an archive file fed one byte per beat: magic and version check,
// directory records, then decrypted payload bytes.
// ============================================================================
//
// Channel  Dir  Beat content
// s_axis   in   tdata = data_byte, tlast = last_byte
// m_axis   out  tdata = out_byte, entry_size, entry_start, entry_time,
//               payload_offset; tuser = kind, encrypted; tlast = name_last
// cfg      in   cfg_we_i / cfg_wdata_i write the xor key
//
// One input beat is taken every cycle while results keep draining; each beat
// passes through the front end and then the back end.
// Each result is registered in the command queue and then in the back end's
// output register; beats that produce no result are dropped there.
// The front end stalls only when the two-entry command queue is full, which
// happens when the result side holds tready low.
// Reset clears all control state and loads the key with 0xF7.
//
// The front end owns the format state machine: it matches the magic both raw
// and against the key, checks the version, walks the record fields and maps
// name characters. Every accepted beat becomes one command, even a beat that
// gives no result, so the back end can count file offsets. The back end
// assembles the size and time fields lane by lane, keeps the wrapping sum of
// entry sizes, and formats the result beat. The last byte of a file resets
// both halves so the next beat opens a new archive.
module archive_directory_parser_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Configuration: xor key byte.
  input  logic         cfg_we_i,
  input  logic [7:0]   cfg_wdata_i,
  // Input stream.
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,    // [7:0] data_byte
  input  logic         s_axis_tlast,
  // Result stream.
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [7:0] out_byte, [39:8] entry_size, [71:40] entry_start,
  // [135:72] entry_time, [167:136] payload_offset
  output logic [167:0] m_axis_tdata,
  output logic [3:0]   m_axis_tuser,    // [2:0] kind, [3] encrypted
  output logic         m_axis_tlast
);
  import adp_pkg::*;

  logic [7:0] key_q;

  cmd_t front_cmd;
  cmd_t queue_cmd;
  logic front_valid;
  logic queue_ready;
  logic queue_valid;
  logic queue_pop;

  logic [2:0]  res_kind;
  logic [7:0]  res_byte;
  logic [31:0] res_size;
  logic [31:0] res_start;
  logic [63:0] res_time;
  logic [31:0] res_poff;
  logic        res_enc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= KEY_RESET;
    end else if (cfg_we_i) begin
      key_q <= cfg_wdata_i;
    end
  end

  adp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .key_i       (key_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_byte_i   (s_axis_tdata),
    .in_last_i   (s_axis_tlast),
    .cmd_ready_i (queue_ready),
    .cmd_valid_o (front_valid),
    .cmd_o       (front_cmd)
  );

  adp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_valid),
    .ready_o (queue_ready),
    .data_i  (front_cmd),
    .valid_o (queue_valid),
    .pop_i   (queue_pop),
    .data_o  (queue_cmd)
  );

  adp_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_valid_i     (queue_valid),
    .cmd_pop_o       (queue_pop),
    .cmd_i           (queue_cmd),
    .res_valid_o     (m_axis_tvalid),
    .res_ready_i     (m_axis_tready),
    .res_kind_o      (res_kind),
    .res_byte_o      (res_byte),
    .res_name_last_o (m_axis_tlast),
    .res_size_o      (res_size),
    .res_start_o     (res_start),
    .res_time_o      (res_time),
    .res_poff_o      (res_poff),
    .res_encrypted_o (res_enc)
  );

  assign m_axis_tdata = {res_poff, res_time, res_start, res_size, res_byte};
  assign m_axis_tuser = {res_enc, res_kind};

endmodule
